@@ hw/rtl/diagonal_gradient_pixel_top_macros.svh @@
// Assertion helpers shared by the gradient block.
`ifndef DIAGONAL_GRADIENT_PIXEL_TOP_MACROS_SVH
`define DIAGONAL_GRADIENT_PIXEL_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DGP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define DGP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/dgp_pkg.sv @@
package dgp_pkg;

   localparam int COLOR_BITS   = 24;
   localparam int CHAN_BITS    = 8;
   localparam int NUM_CHANS    = 3;
   localparam int ALPHA_BITS   = 8;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES   = ALPHA_BITS / DIV_BITS_PER_STAGE;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;
   localparam int BLEND_BITS   = 2 * CHAN_BITS;

   localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = 8'hFF;

   localparam int RESET_WIDTH  = 1024;
   localparam int RESET_HEIGHT = 768;
   localparam logic [COLOR_BITS-1:0] RESET_DARK  = 24'h0A1018;
   localparam logic [COLOR_BITS-1:0] RESET_LIGHT = 24'h182030;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_WIDTH  = 3'd0,
      REG_HEIGHT = 3'd1,
      REG_DARK   = 3'd2,
      REG_LIGHT  = 3'd3
   } dgp_reg_type;

   typedef struct packed {
      logic                  den_zero;
      logic [COLOR_BITS-1:0] dark;
      logic [COLOR_BITS-1:0] light;
   } dgp_colors_type;

endpackage

@@ hw/rtl/dgp_csr.sv @@
module dgp_csr import dgp_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output logic [COORD_BITS+1:0]     den,
   output dgp_colors_type            colors
);

   localparam int SW = COORD_BITS + 1;

   logic [SW-1:0]         width_ff,  width_in;
   logic [SW-1:0]         height_ff, height_in;
   logic [COLOR_BITS-1:0] dark_ff,   dark_in;
   logic [COLOR_BITS-1:0] light_ff,  light_in;
   logic [SW-1:0]         width_m1;
   logic [SW-1:0]         height_m1;

   assign csr_ready = !reset;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      dark_in   = dark_ff;
      light_in  = light_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WIDTH:  width_in  = csr_wdata[SW-1:0];
            REG_HEIGHT: height_in = csr_wdata[SW-1:0];
            REG_DARK:   dark_in   = csr_wdata[COLOR_BITS-1:0];
            REG_LIGHT:  light_in  = csr_wdata[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SW'(RESET_WIDTH);
         height_ff <= SW'(RESET_HEIGHT);
         dark_ff   <= RESET_DARK;
         light_ff  <= RESET_LIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         dark_ff   <= dark_in;
         light_ff  <= light_in;
      end
   end

   // zero size counts as one, so size-1 floors at zero
   assign width_m1  = (width_ff  == '0) ? '0 : width_ff  - SW'(1);
   assign height_m1 = (height_ff == '0) ? '0 : height_ff - SW'(1);
   assign den       = {1'b0, width_m1} + {1'b0, height_m1};

   assign colors.den_zero = (den == '0);
   assign colors.dark     = dark_ff;
   assign colors.light    = light_ff;

endmodule

@@ hw/rtl/dgp_alpha.sv @@
module dgp_alpha import dgp_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [COORD_BITS-1:0] pixel_x,
   input  logic [COORD_BITS-1:0] pixel_y,
   input  logic [COORD_BITS+1:0] den,
   output logic                  out_valid,
   output logic [ALPHA_BITS-1:0] alpha
);

   localparam int SW = COORD_BITS + 1;
   localparam int DW = COORD_BITS + 2;
   localparam int NW = DW + ALPHA_BITS;

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
                                            input logic           bit_in,
                                            input logic [DW-1:0] divisor);
      logic [DW:0] trial;
      logic [DW:0] diff;
      trial = {rem, bit_in};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         div_step = {1'b1, diff[DW-1:0]};
      end else begin
         div_step = {1'b0, trial[DW-1:0]};
      end
   endfunction

   logic [SW-1:0]         sum_ff, sum_in;
   logic                  sum_vld_ff;
   logic [DW-1:0]         num;
   logic [NW-1:0]         dividend;

   logic [DW-1:0]         rem_ff [0:DIV_STAGES];
   logic [DW-1:0]         rem_in [0:DIV_STAGES];
   logic [ALPHA_BITS-1:0] quo_ff [0:DIV_STAGES];
   logic [ALPHA_BITS-1:0] quo_in [0:DIV_STAGES];
   logic [ALPHA_BITS-1:0] low_ff [0:DIV_STAGES];
   logic [ALPHA_BITS-1:0] low_in [0:DIV_STAGES];
   logic [DIV_STAGES:0]   vld_ff;

   assign sum_in = {1'b0, pixel_x} + {1'b0, pixel_y};

   // clamp to den, then num*255 as num*256 - num
   assign num      = ({1'b0, sum_ff} > den) ? den : {1'b0, sum_ff};
   assign dividend = {num, {ALPHA_BITS{1'b0}}} - {{ALPHA_BITS{1'b0}}, num};

   always_comb begin
      logic [DW-1:0]         r;
      logic [ALPHA_BITS-1:0] q;
      logic [ALPHA_BITS-1:0] l;
      logic [DW:0]           step;
      // quotient fits 8 bits, so the high part already sits below den
      rem_in[0] = dividend[NW-1:ALPHA_BITS];
      low_in[0] = dividend[ALPHA_BITS-1:0];
      quo_in[0] = '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         r = rem_ff[k-1];
         q = quo_ff[k-1];
         l = low_ff[k-1];
         for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
            step = div_step(r, l[ALPHA_BITS-1], den);
            r    = step[DW-1:0];
            q    = {q[ALPHA_BITS-2:0], step[DW]};
            l    = {l[ALPHA_BITS-2:0], 1'b0};
         end
         rem_in[k] = r;
         quo_in[k] = q;
         low_in[k] = l;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= 1'b0;
         vld_ff     <= '0;
      end else begin
         sum_vld_ff <= in_valid;
         vld_ff     <= {vld_ff[DIV_STAGES-1:0], sum_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      for (int k = 0; k <= DIV_STAGES; k++) begin
         rem_ff[k] <= rem_in[k];
         quo_ff[k] <= quo_in[k];
         low_ff[k] <= low_in[k];
      end
   end

   assign out_valid = vld_ff[DIV_STAGES];
   assign alpha     = quo_ff[DIV_STAGES];

endmodule

@@ hw/rtl/dgp_blend.sv @@
module dgp_blend import dgp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [ALPHA_BITS-1:0] alpha,
   input  dgp_colors_type        colors,
   output logic                  out_valid,
   output logic [COLOR_BITS-1:0] pixel_color
);

   localparam int PW = 2 * BLEND_BITS;

   logic [BLEND_BITS-1:0] mix_ff [0:NUM_CHANS-1];
   logic [BLEND_BITS-1:0] mix_in [0:NUM_CHANS-1];
   logic                  mix_vld_ff;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic                  color_vld_ff;
   logic [ALPHA_BITS-1:0] inv_alpha;

   assign inv_alpha = ALPHA_MAX - alpha;

   always_comb begin
      logic [BLEND_BITS-1:0] d;
      logic [BLEND_BITS-1:0] l;
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         d = {{CHAN_BITS{1'b0}}, colors.dark[ch*CHAN_BITS +: CHAN_BITS]};
         l = {{CHAN_BITS{1'b0}}, colors.light[ch*CHAN_BITS +: CHAN_BITS]};
         mix_in[ch] = d * {{CHAN_BITS{1'b0}}, inv_alpha}
                    + l * {{CHAN_BITS{1'b0}}, alpha};
      end
   end

   // v/255 == (v*0x8081) >> 23 for v up to 255*255; 0x8081 = 2^15+2^7+1
   always_comb begin
      logic [PW-1:0] scaled;
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         scaled = {1'b0, mix_ff[ch], 15'b0}
                + {9'b0, mix_ff[ch], 7'b0}
                + {16'b0, mix_ff[ch]};
         color_in[ch*CHAN_BITS +: CHAN_BITS] = scaled[30:23];
      end
      if (colors.den_zero) begin
         color_in = colors.dark;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_vld_ff   <= 1'b0;
         color_vld_ff <= 1'b0;
      end else begin
         mix_vld_ff   <= in_valid;
         color_vld_ff <= mix_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         mix_ff[ch] <= mix_in[ch];
      end
      color_ff <= color_in;
   end

   assign out_valid   = color_vld_ff;
   assign pixel_color = color_ff;

endmodule

@@ hw/rtl/diagonal_gradient_pixel_top.sv @@
// Diagonal gradient pixel generator.
// Input channel: drive start with req_pixel_x / req_pixel_y; a word is taken
//   at each rising edge where start is high and busy is low. busy is high
//   only while reset is asserted, so a new coordinate may enter every cycle.
// Result channel: rsp_valid strobes for one cycle with rsp_pixel_color
//   (red 23:16, green 15:8, blue 7:0). The receiver cannot stall; every
//   result appears exactly once, in input order.
// Throughput: one word per cycle while reset is low. The pipeline
//   registers, in order: coordinate add, clamp and x255, four
//   radix-4 stages of the alpha divider (two restoring steps each), the
//   per-channel multiply-add, and the divide-by-255 output stage.
// Config: csr_valid / csr_ready with csr_index (0 width, 1 height,
//   2 dark color, 3 light color) and csr_wdata; other indexes are ignored.
//   Write only while the pipeline is empty; settings take effect for words
//   accepted on the next cycle.
// Reset: synchronous, active high; clears the pipeline valids and loads
//   1024x768 with the default dark and light colors.
`include "diagonal_gradient_pixel_top_macros.svh"

module diagonal_gradient_pixel_top import dgp_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   // input channel
   input  logic                      start,
   output logic                      busy,
   input  logic [COORD_BITS-1:0]     req_pixel_x,
   input  logic [COORD_BITS-1:0]     req_pixel_y,
   // result channel
   output logic                      rsp_valid,
   output logic [COLOR_BITS-1:0]     rsp_pixel_color,
   // config write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int LATENCY = DIV_STAGES + 4;

   logic [COORD_BITS+1:0] den;
   dgp_colors_type        colors;
   logic                  accept;
   logic                  alpha_valid;
   logic [ALPHA_BITS-1:0] alpha;

   // no back-pressure anywhere in the pipe; only reset holds off input
   assign busy   = reset;
   assign accept = start && !busy;

   // config registers and the shared denominator
   dgp_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .den       (den),
      .colors    (colors)
   );

   // alpha = floor(min(x+y, den) * 255 / den), pipelined divider
   dgp_alpha #(
      .COORD_BITS (COORD_BITS)
   ) u_alpha (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .pixel_x   (req_pixel_x),
      .pixel_y   (req_pixel_y),
      .den       (den),
      .out_valid (alpha_valid),
      .alpha     (alpha)
   );

   // per-channel blend and divide by 255; dark color when den is zero
   dgp_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (alpha_valid),
      .alpha       (alpha),
      .colors      (colors),
      .out_valid   (rsp_valid),
      .pixel_color (rsp_pixel_color)
   );

   // every accepted word comes out as a result at the end of the pipeline
   `DGP_ASSERT_NXT(a_latency, clock, reset, accept, ##(LATENCY-1) rsp_valid, "result missing")
   // no result without an accepted word behind it
   `DGP_ASSERT_IMP(a_no_extra, clock, reset, rsp_valid, $past(accept, LATENCY), "extra result")
   // degenerate screen returns the dark color
   `DGP_ASSERT_IMP(a_den_zero, clock, reset, rsp_valid && colors.den_zero, rsp_pixel_color == colors.dark, "bad color for empty gradient")

endmodule
